FILE: src/aes256_block_encrypt_macros.svh
// ----------------------------------------------------------------------------
// AES-256 assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef AES256_BLOCK_ENCRYPT_MACROS_SVH
`define AES256_BLOCK_ENCRYPT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define AES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// S-box, round constants and round functions shared by the AES-256 design.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int NumRounds = 14;
  localparam int NumWords  = 4 * (NumRounds + 1);
  localparam int KeyRegs   = 4;

  typedef logic [127:0] aes_state_t;
  typedef logic [1:0]   cfg_idx_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Index 7 is never used by the AES-256 schedule.
  localparam logic [7:0] RCON [8] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte 0 of the state is the most significant byte.
  function automatic aes_state_t sub_shift(input aes_state_t s);
    aes_state_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic aes_state_t mix_columns(input aes_state_t s);
    aes_state_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32 * c -: 8];
      a1  = s[119 - 32 * c -: 8];
      a2  = s[111 - 32 * c -: 8];
      a3  = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic aes_state_t aes_round(input aes_state_t s, input aes_state_t rk,
                                           input logic last);
    aes_state_t t;
    t = sub_shift(s);
    if (!last) begin
      t = mix_columns(t);
    end
    return t ^ rk;
  endfunction

endpackage

FILE: src/aes_pt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plaintext channel
// Valid/ready channel carrying one 128-bit plaintext block.
// ----------------------------------------------------------------------------
interface aes_pt_if;
  logic        valid;
  logic        ready;
  logic [63:0] plaintext_high;
  logic [63:0] plaintext_low;

  modport source (output valid, plaintext_high, plaintext_low, input ready);
  modport sink   (input valid, plaintext_high, plaintext_low, output ready);
endinterface

FILE: src/aes_ct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ciphertext channel
// Valid/ready channel carrying one 128-bit ciphertext block.
// ----------------------------------------------------------------------------
interface aes_ct_if;
  logic        valid;
  logic        ready;
  logic [63:0] ciphertext_high;
  logic [63:0] ciphertext_low;

  modport source (output valid, ciphertext_high, ciphertext_low, input ready);
  modport sink   (input valid, ciphertext_high, ciphertext_low, output ready);
endinterface

FILE: src/aes_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key register write channel
// Valid/ready channel carrying a key register index and 64-bit write data.
// ----------------------------------------------------------------------------
interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/aes256_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 block encryption
// Fifteen-stage round pipeline with a word-serial key expander.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction
//  cfg_if   in         key register write, index 0..3, 64-bit data
//  in_if    in         plaintext block, plaintext_high / plaintext_low
//  out_if   out        ciphertext block, ciphertext_high / ciphertext_low
//
// Each block passes one register stage for the initial AddRoundKey and one
// per round; one block enters every cycle while the output is not stalled.
// After reset and after every key write the expander produces one schedule
// word per cycle, 52 words in all, while in_if.ready is held low.
// A stalled output holds its stage; earlier stages keep filling bubbles.
// ----------------------------------------------------------------------------
module aes256_block_encrypt (
  input logic clk_i,
  input logic rst_ni,
  aes_cfg_if.sink cfg_if,
  aes_pt_if.sink  in_if,
  aes_ct_if.source out_if
);
  import aes_pkg::*;

  localparam int Stages = NumRounds + 1;

  // Key registers and expansion control.
  logic [63:0] key_q [KeyRegs];
  logic        keys_ready_q;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] win_q [8];
  logic [31:0] win_src [8];
  logic [31:0] new_word, tmp;
  logic [31:0] rk_q [NumWords];
  logic        cfg_wr;

  // Round pipeline.
  aes_state_t st_q [Stages];
  logic       v_q  [Stages];
  logic       rdy  [Stages];

  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyRegs; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      key_q[cfg_if.index] <= cfg_if.data;
    end
  end

  // The window holds the last eight schedule words; on the first step it is
  // taken straight from the key registers.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      win_src[i] = (cnt_q == 6'd8) ? (i[0] ? key_q[i / 2][31:0] : key_q[i / 2][63:32])
                                   : win_q[i];
    end
    tmp = win_src[7];
    if (cnt_q[2:0] == 3'd0) begin
      tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {RCON[cnt_q[5:3] - 3'd1], 24'h0};
    end else if (cnt_q[2:0] == 3'd4) begin
      tmp = sub_word(tmp);
    end
    new_word = win_src[0] ^ tmp;
    cnt_d    = cnt_q + 6'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_ready_q <= 1'b0;
      cnt_q        <= 6'd8;
    end else if (cfg_wr) begin
      keys_ready_q <= 1'b0;
      cnt_q        <= 6'd8;
    end else if (!keys_ready_q) begin
      if (cnt_q == 6'(NumWords - 1)) begin
        keys_ready_q <= 1'b1;
      end else begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!keys_ready_q && !cfg_wr) begin
      for (int i = 0; i < 7; i++) begin
        win_q[i] <= win_src[i + 1];
      end
      win_q[7]     <= new_word;
      rk_q[cnt_q]  <= new_word;
      if (cnt_q == 6'd8) begin
        for (int i = 0; i < 8; i++) begin
          rk_q[i] <= win_src[i];
        end
      end
    end
  end

  // Each stage advances when it is empty or its successor takes its block.
  always_comb begin
    rdy[Stages - 1] = !v_q[Stages - 1] || out_if.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k + 1];
    end
  end

  assign in_if.ready = keys_ready_q && rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Stages; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_if.valid && in_if.ready;
      end
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      st_q[0] <= {in_if.plaintext_high, in_if.plaintext_low} ^
                 {rk_q[0], rk_q[1], rk_q[2], rk_q[3]};
    end
    for (int k = 1; k < Stages; k++) begin
      if (rdy[k] && v_q[k - 1]) begin
        st_q[k] <= aes_round(st_q[k - 1],
                             {rk_q[4 * k], rk_q[4 * k + 1], rk_q[4 * k + 2], rk_q[4 * k + 3]},
                             k == Stages - 1);
      end
    end
  end

  assign out_if.valid           = v_q[Stages - 1];
  assign out_if.ciphertext_high = st_q[Stages - 1][127:64];
  assign out_if.ciphertext_low  = st_q[Stages - 1][63:0];

endmodule

FILE: src/aes_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 port checker
// Port-level assertions on the key, plaintext and ciphertext channels.
// ----------------------------------------------------------------------------
`include "aes256_block_encrypt_macros.svh"

module aes_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_high_i,
  input logic [63:0] out_low_i
);

  // A key write always starts a new expansion, so no block enters next cycle.
  `AES_ASSERT_NEXT(a_key_wr_blocks_in, clk_i, rst_ni, cfg_valid_i && cfg_ready_i, !in_ready_i)
  // While the first schedule word of a new expansion is made, the input stays closed.
  `AES_ASSERT_SAME(a_exp_closed, clk_i, rst_ni, $past(cfg_valid_i && cfg_ready_i), !in_ready_i)
  `AES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `AES_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   $stable(out_high_i) && $stable(out_low_i))

endmodule

bind aes256_block_encrypt aes_chk u_aes_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_if.valid),
  .cfg_ready_i (cfg_if.ready),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_high_i  (out_if.ciphertext_high),
  .out_low_i   (out_if.ciphertext_low)
);
